### sv/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

	// width of the capacity register and of the fault counter
	localparam int unsigned CAP_BITS = 4;
	localparam int unsigned FAULT_BITS = 32;
	localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

	// operation broadcast to every cell in the update cycle
	typedef struct packed {
		logic update;
		logic hit;
		logic evict;
	} op_t;

endpackage

### sv/lrupr_cell.sv
`timescale 1ns / 1ps

module lrupr_cell #(
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lrupr_pkg::op_t       op,
	input  logic [PAGE_BITS-1:0] ref_page,
	input  logic [PAGE_BITS-1:0] prev_page,
	input  logic                 prev_valid,
	input  logic                 next_valid,
	input  logic                 en_in,
	input  logic [PAGE_BITS-1:0] drop_in,
	output logic [PAGE_BITS-1:0] page,
	output logic                 valid,
	output logic                 match,
	output logic                 en_out,
	output logic [PAGE_BITS-1:0] drop_out
);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 stop;

	assign page  = page_q;
	assign valid = valid_q;
	assign match = valid_q && (page_q == ref_page);

	// the shift stops at the hit cell, at the last valid cell on an eviction,
	// or at the first free cell on a fill
	always_comb begin
		if (op.hit) begin
			stop = match;
		end else if (op.evict) begin
			stop = valid_q && !next_valid;
		end else begin
			stop = !valid_q;
		end
	end

	assign en_out   = en_in && !stop;
	assign drop_out = drop_in | ((op.evict && en_in && stop) ? page_q : '0);

	always_ff @(posedge clk) begin
		if (op.update && en_in) begin
			page_q <= prev_page;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.update && en_in) begin
			valid_q <= prev_valid;
		end
	end

endmodule

### sv/lru_page_replacement_unit.sv
`timescale 1ns / 1ps

// LRU page replacement over a fully associative set of FRAMES frames, kept as
// a chain of cells ordered by recency (cell 0 most recent). A reference is
// accepted when start is high and busy is low; busy then stays high for one
// cycle while every cell compares the page and the chain shifts toward the
// hit, eviction or free cell. The result appears with done for exactly one
// cycle on the following cycle and cannot be held off; a new start may be
// given in the cycle done is shown. capacity is to be written through
// cfg_we/cfg_data only while the unit is idle, which the block does not
// enforce; values of zero act as one and values above FRAMES act as FRAMES.
// Frames start empty after reset.
module lru_page_replacement_unit #(
	parameter int unsigned FRAMES    = 8,
	parameter int unsigned PAGE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [PAGE_BITS-1:0]                 page_id,
	input  logic                                 cfg_we,
	input  logic [lrupr_pkg::CAP_BITS-1:0]       cfg_data,
	output logic                                 done,
	output logic                                 fault,
	output logic                                 evicted_valid,
	output logic [PAGE_BITS-1:0]                 evicted_page,
	output logic [lrupr_pkg::FAULT_BITS-1:0]     fault_count
);

	localparam int unsigned CNT_W = $clog2(FRAMES + 1);
	localparam int unsigned CMP_W = (CNT_W > lrupr_pkg::CAP_BITS) ? CNT_W : lrupr_pkg::CAP_BITS;

	logic [lrupr_pkg::CAP_BITS-1:0]   cap_q;
	logic                             busy_q;
	logic [PAGE_BITS-1:0]             page_q;
	logic [CNT_W-1:0]                 count_q;
	logic [lrupr_pkg::FAULT_BITS-1:0] total_q;

	logic [PAGE_BITS-1:0] cell_page [FRAMES];
	logic [FRAMES-1:0]    cell_valid;
	logic [FRAMES-1:0]    cell_match;
	logic [FRAMES:0]      en_chain;
	logic [PAGE_BITS-1:0] drop_chain [FRAMES+1];

	logic [CMP_W-1:0]                 cap_ext;
	logic [CMP_W-1:0]                 usable;
	logic                             hit;
	logic                             full;
	lrupr_pkg::op_t                   op;
	logic [lrupr_pkg::FAULT_BITS-1:0] total_nxt;

	assign busy = busy_q;

	always_comb begin
		cap_ext = CMP_W'(cap_q);
		if (cap_ext == '0) begin
			usable = CMP_W'(1);
		end else if (cap_ext > CMP_W'(FRAMES)) begin
			usable = CMP_W'(FRAMES);
		end else begin
			usable = cap_ext;
		end
	end

	assign hit       = |cell_match;
	assign full      = CMP_W'(count_q) >= usable;
	assign op.update = busy_q;
	assign op.hit    = hit;
	assign op.evict  = !hit && full;

	assign total_nxt = (total_q == '1) ? total_q : total_q + 1'b1;

	assign en_chain[0]   = 1'b1;
	assign drop_chain[0] = '0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		logic [PAGE_BITS-1:0] prev_page;
		logic                 prev_valid;
		logic                 next_valid;

		if (i == 0) begin : g_head
			assign prev_page  = page_q;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_page  = cell_page[i-1];
			assign prev_valid = cell_valid[i-1];
		end

		if (i == FRAMES - 1) begin : g_tail
			assign next_valid = 1'b0;
		end else begin : g_next
			assign next_valid = cell_valid[i+1];
		end

		lrupr_cell #(
			.PAGE_BITS(PAGE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.ref_page  (page_q),
			.prev_page (prev_page),
			.prev_valid(prev_valid),
			.next_valid(next_valid),
			.en_in     (en_chain[i]),
			.drop_in   (drop_chain[i]),
			.page      (cell_page[i]),
			.valid     (cell_valid[i]),
			.match     (cell_match[i]),
			.en_out    (en_chain[i+1]),
			.drop_out  (drop_chain[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			page_q <= page_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= lrupr_pkg::CAP_RESET;
			busy_q  <= 1'b0;
			count_q <= '0;
			total_q <= '0;
			done    <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			busy_q <= start && !busy_q;
			done   <= busy_q;
			if (busy_q && !hit) begin
				total_q <= total_nxt;
				if (!full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// result payload, qualified by done
	always_ff @(posedge clk) begin
		if (busy_q) begin
			fault         <= !hit;
			evicted_valid <= op.evict;
			evicted_page  <= drop_chain[FRAMES];
			fault_count   <= hit ? total_q : total_nxt;
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q))
		else $error("result without an update cycle");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held for more than one cycle");

	a_evict_is_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted_valid) |-> fault)
		else $error("eviction reported on a hit");

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(count_q))
		else $error("resident count out of step with valid cells");

endmodule

### tb/tb_lru_page_replacement_unit.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement_unit;

	localparam int unsigned FRAMES = 8;
	localparam int unsigned PAGE_BITS = 16;
	localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned PHASE_REFS = 100;

	typedef struct packed {
		logic                             fault;
		logic                             evicted_valid;
		logic [PAGE_BITS-1:0]             evicted_page;
		logic [lrupr_pkg::FAULT_BITS-1:0] fault_count;
	} ref_outcome_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic [PAGE_BITS-1:0]             page_id = '0;
	logic                             cfg_we = 1'b0;
	logic [lrupr_pkg::CAP_BITS-1:0]   cfg_data = '0;
	logic                             busy;
	logic                             done;
	logic                             fault;
	logic                             evicted_valid;
	logic [PAGE_BITS-1:0]             evicted_page;
	logic [lrupr_pkg::FAULT_BITS-1:0] fault_count;

	// shadow of the frame set, ordered by recency rank
	logic [PAGE_BITS-1:0]             frame_page [FRAMES];
	bit                               frame_valid [FRAMES];
	int unsigned                      frame_rank [FRAMES];
	int unsigned                      resident_pages;
	logic [lrupr_pkg::FAULT_BITS-1:0] fault_total;
	logic [lrupr_pkg::CAP_BITS-1:0]   capacity_reg;

	logic [PAGE_BITS-1:0]  pending_refs [$];
	ref_outcome_t          expected_outcomes [$];
	logic [PAGE_BITS-1:0]  page_pool [$];
	int unsigned           sender_idle_pct;
	int unsigned           mismatches;

	lru_page_replacement_unit #(
		.FRAMES(FRAMES),
		.PAGE_BITS(PAGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.page_id(page_id),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.fault(fault),
		.evicted_valid(evicted_valid),
		.evicted_page(evicted_page),
		.fault_count(fault_count)
	);

	always #5 clk = ~clk;

	function automatic int unsigned usable_frames();
		if (capacity_reg == 0) return 1;
		if (capacity_reg > FRAMES) return FRAMES;
		return int'(capacity_reg);
	endfunction

	function automatic void age_frames(int unsigned limit);
		for (int i = 0; i < FRAMES; i++)
			if (frame_valid[i] && frame_rank[i] < limit) frame_rank[i]++;
	endfunction

	function automatic ref_outcome_t lookup_page(logic [PAGE_BITS-1:0] page);
		ref_outcome_t o;
		int hit_slot;
		int slot;
		int unsigned oldest;
		o = '0;
		hit_slot = -1;
		slot = -1;
		oldest = 0;
		for (int i = 0; i < FRAMES; i++)
			if (hit_slot < 0 && frame_valid[i] && frame_page[i] == page) hit_slot = i;
		if (hit_slot >= 0) begin
			age_frames(frame_rank[hit_slot]);
			frame_rank[hit_slot] = 0;
			o.fault_count = fault_total;
			return o;
		end
		if (fault_total != '1) fault_total++;
		if (resident_pages >= usable_frames()) begin
			// replace the least recently used page
			for (int i = 0; i < FRAMES; i++)
				if (frame_valid[i] && (slot < 0 || frame_rank[i] > oldest)) begin
					slot = i;
					oldest = frame_rank[i];
				end
			if (slot >= 0) begin
				o.evicted_valid = 1'b1;
				o.evicted_page = frame_page[slot];
				frame_valid[slot] = 1'b0;
				age_frames(32'hffff_ffff);
			end
		end else begin
			for (int i = 0; i < FRAMES; i++)
				if (slot < 0 && !frame_valid[i]) slot = i;
			if (slot >= 0) begin
				age_frames(32'hffff_ffff);
				resident_pages++;
			end
		end
		if (slot >= 0) begin
			frame_page[slot] = page;
			frame_valid[slot] = 1'b1;
			frame_rank[slot] = 0;
		end
		o.fault = 1'b1;
		o.fault_count = fault_total;
		return o;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// driver: one reference per transaction, start held until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			page_id <= '0;
		end else begin
			if (start && !busy) expected_outcomes.push_back(lookup_page(page_id));
			if (!start || !busy) begin
				if (pending_refs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					page_id <= pending_refs.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ref_outcome_t want;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				report("result with no outstanding reference");
			end else begin
				want = expected_outcomes.pop_front();
				if (fault !== want.fault)
					report($sformatf("fault %b, expected %b", fault, want.fault));
				if (evicted_valid !== want.evicted_valid)
					report($sformatf("evicted_valid %b, expected %b",
						evicted_valid, want.evicted_valid));
				if (evicted_page !== want.evicted_page)
					report($sformatf("evicted_page %h, expected %h",
						evicted_page, want.evicted_page));
				if (fault_count !== want.fault_count)
					report($sformatf("fault_count %0d, expected %0d",
						fault_count, want.fault_count));
			end
		end
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_refs.size() != 0 || start || expected_outcomes.size() != 0);
	endtask

	task automatic write_capacity(input logic [lrupr_pkg::CAP_BITS-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		capacity_reg = value;
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_refs(input logic [PAGE_BITS-1:0] pages [$]);
		foreach (pages[i]) pending_refs.push_back(pages[i]);
	endtask

	// mostly references to a working set from the capacity to four pages above it
	task automatic queue_random_refs(input int unsigned count);
		int unsigned pick;
		page_pool.delete();
		repeat (usable_frames() + $urandom_range(4))
			page_pool.push_back(PAGE_BITS'($urandom_range(0, 65535)));
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 85)
				pending_refs.push_back(page_pool[$urandom_range(page_pool.size() - 1)]);
			else if (pick < 93)
				pending_refs.push_back(PAGE_BITS'($urandom_range(0, 65535)));
			else
				pending_refs.push_back(pick[0] ? PAGE_MAX : '0);
		end
	endtask

	initial begin
		for (int i = 0; i < FRAMES; i++) begin
			frame_page[i] = '0;
			frame_valid[i] = 1'b0;
			frame_rank[i] = 0;
		end
		resident_pages = 0;
		fault_total = '0;
		capacity_reg = lrupr_pkg::CAP_RESET;
		mismatches = 0;
		sender_idle_pct = 13;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill all frames at reset capacity, hit, then evict in lru order
		queue_refs('{16'h0000, PAGE_MAX, 16'h0001, 16'h0000, 16'h0002, 16'h0003,
			16'h0004, 16'h0005, 16'h0006, 16'h8000, PAGE_MAX, 16'h0000, 16'h0001});
		// capacity dropped below residency: misses recycle lru frames only
		write_capacity(4'd2);
		queue_refs('{16'h1234, 16'h0000, 16'h5678, 16'h1234, 16'h0000});
		// zero behaves as one frame
		write_capacity(4'd0);
		queue_refs('{16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA});
		// above the frame count behaves as the full set
		write_capacity(4'd15);
		queue_refs('{16'h0F0F, 16'hF0F0, 16'h0F0F});

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			logic [lrupr_pkg::CAP_BITS-1:0] caps [RANDOM_PHASES];
			caps = '{4'd1, 4'd9, 4'd6, 4'd0, 4'd3, 4'd15, 4'd2, 4'd8};
			if (p == 2 || p == 5) caps[p] = lrupr_pkg::CAP_BITS'($urandom_range(0, 15));
			write_capacity(caps[p]);
			sender_idle_pct = (p < 3) ? 13 : (p < 6) ? 75 : 0;
			queue_random_refs(PHASE_REFS);
		end

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS lru_page_replacement_unit");
		else
			$display("FAIL lru_page_replacement_unit");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL lru_page_replacement_unit");
		$finish;
	end

endmodule

### filelist.f
sv/lrupr_pkg.sv
sv/lrupr_cell.sv
sv/lru_page_replacement_unit.sv
tb/tb_lru_page_replacement_unit.sv
